@@ rtl/gaussian_fingerprint_matcher_macros.svh @@
// Assertion macros for the fingerprint matcher.
`ifndef GAUSSIAN_FINGERPRINT_MATCHER_MACROS_SVH
`define GAUSSIAN_FINGERPRINT_MATCHER_MACROS_SVH

// property checked on every edge outside reset
`define GFM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// antecedent this cycle, consequent next cycle
`define GFM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/gfm_pkg.sv @@
// Shared constants and types of the fingerprint matcher.
package gfm_pkg;

  localparam int NUM_LOCATIONS     = 8;
  localparam int NUM_ACCESS_POINTS = 4;
  localparam int LOC_IDX_W = (NUM_LOCATIONS > 1) ? $clog2(NUM_LOCATIONS) : 1;
  localparam int AP_IDX_W  = (NUM_ACCESS_POINTS > 1) ? $clog2(NUM_ACCESS_POINTS) : 1;

  localparam int VAL_W     = 16;
  localparam int NUM_READINGS = 4;
  localparam int Q_W       = 49;
  localparam int DIV_STEPS = Q_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int LOG_STEPS = 16;
  localparam int LN_W      = 21;
  localparam int SUM_W     = 52;

  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam int          LN256_Q16 = 363409;

  localparam logic signed [31:0] COST_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COST_MIN = 32'sh8000_0000;
  localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(COST_MAX);
  localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(COST_MIN);

  typedef struct packed {
    logic clr;
    logic load;
    logic dstep;
    logic lstep;
    logic fin;
    logic acc;
    logic scan;
  } gfm_ctl_t;

  typedef struct packed {
    logic signed [31:0]   cost;
    logic [LOC_IDX_W-1:0] loc;
    logic                 flag;
  } gfm_link_t;

endpackage

@@ rtl/gfm_log.sv @@
// Iterative natural log of a Q8.8 spread, result in signed Q4.16 (21 bits).
module gfm_log (
  input  logic                          clk,
  input  gfm_pkg::gfm_ctl_t             ctl,
  input  logic [15:0]                   spread,
  output logic signed [gfm_pkg::LN_W-1:0] ln_q
);
  import gfm_pkg::*;

  logic [3:0]  p;
  logic [3:0]  pw;
  logic [30:0] m;
  logic [30:0] m_init;
  logic [15:0] frac;
  logic [61:0] sq;
  logic [31:0] t;
  logic [52:0] rnd;
  logic signed [LN_W-1:0] lnv_s;

  always_comb begin
    p = '0;
    for (int i = 0; i < 16; i++) begin
      if (spread[i]) p = 4'(i);
    end
  end

  assign m_init = 31'(32'(spread) << (5'd30 - {1'b0, p}));
  assign sq     = {31'b0, m} * {31'b0, m};
  assign t      = sq[61:30];
  assign rnd    = 53'({pw, frac}) * 53'(LN2_Q32) + 53'(64'h8000_0000);
  assign lnv_s  = LN_W'({1'b0, rnd[51:32]});

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      m    <= m_init;
      frac <= '0;
      pw   <= p;
    end else if (ctl.lstep) begin
      m    <= t[31] ? t[31:1] : t[30:0];
      frac <= {frac[14:0], t[31]};
    end
    if (ctl.fin) begin
      ln_q <= lnv_s - LN_W'(LN256_Q16);
    end
  end

endmodule

@@ rtl/gfm_cell.sv @@
// One location: calibration entries, cost term unit, accumulator and min stage.
module gfm_cell (
  input  logic                             clk,
  input  gfm_pkg::gfm_ctl_t                ctl,
  input  logic                             we,
  input  logic [gfm_pkg::AP_IDX_W-1:0]     ap,
  input  logic [15:0]                      wmean,
  input  logic [15:0]                      wspread,
  input  logic [15:0]                      reading,
  input  logic                             is_first,
  input  logic [gfm_pkg::LOC_IDX_W-1:0]    my_loc,
  input  gfm_pkg::gfm_link_t               link_in,
  output gfm_pkg::gfm_link_t               link_out
);
  import gfm_pkg::*;

  logic [15:0] mean_mem   [NUM_ACCESS_POINTS];
  logic [15:0] spread_mem [NUM_ACCESS_POINTS];

  logic [15:0] m_rd, s_rd, d;
  logic [31:0] d2, s2;
  logic [Q_W-1:0] num;
  logic [32:0] den;
  logic [32:0] rem;
  logic [33:0] rem_sh;
  logic [33:0] diff;
  logic        qbit;
  logic        zt;
  logic        zero;
  logic signed [SUM_W-1:0] sum;
  logic signed [31:0] own_cost;
  logic signed [LN_W-1:0] ln_q;
  logic        take;

  gfm_log u_log (
    .clk    (clk),
    .ctl    (ctl),
    .spread (s_rd),
    .ln_q   (ln_q)
  );

  assign m_rd   = mean_mem[ap];
  assign s_rd   = spread_mem[ap];
  assign d      = (reading >= m_rd) ? (reading - m_rd) : (m_rd - reading);
  assign d2     = 32'(d) * 32'(d);
  assign s2     = 32'(s_rd) * 32'(s_rd);
  assign rem_sh = {rem, num[Q_W-1]};
  assign diff   = rem_sh - {1'b0, den};
  assign qbit   = rem_sh >= {1'b0, den};

  always_comb begin
    if (zero || sum > SUM_HI) begin
      own_cost = COST_MAX;
    end else if (sum < SUM_LO) begin
      own_cost = COST_MIN;
    end else begin
      own_cost = sum[31:0];
    end
  end

  assign take = is_first || (own_cost < link_in.cost);

  always_ff @(posedge clk) begin
    if (we) begin
      mean_mem[ap]   <= wmean;
      spread_mem[ap] <= wspread;
    end
    if (ctl.load) begin
      num <= Q_W'({d2, 16'b0}) + Q_W'(s2);
      den <= {s2, 1'b0};
      rem <= '0;
      zt  <= (s_rd == '0);
    end else if (ctl.dstep) begin
      rem <= qbit ? diff[32:0] : rem_sh[32:0];
      num <= {num[Q_W-2:0], qbit};
    end
    if (ctl.clr) begin
      sum  <= '0;
      zero <= 1'b0;
    end else if (ctl.acc) begin
      if (zt) begin
        zero <= 1'b1;
      end else begin
        sum <= sum + $signed({{(SUM_W-LN_W){ln_q[LN_W-1]}}, ln_q})
                   + $signed(SUM_W'(num));
      end
    end
    if (ctl.scan) begin
      link_out.cost <= take ? own_cost : link_in.cost;
      link_out.loc  <= take ? my_loc : link_in.loc;
      link_out.flag <= link_in.flag | zero;
    end
  end

endmodule

@@ rtl/gaussian_fingerprint_matcher.sv @@
// Top level: command port, sequencer and the row of location cells.
//
//  channel   | handshake         | words
//  ----------+-------------------+-------------------------------------------
//  command   | start, busy       | operation, location, access_point,
//            |                   | entry_mean, entry_spread, reading0..3
//  result    | done (one cycle)  | best_location, best_cost, zero_spread_seen
//
// A load is written straight into the cell tables and keeps busy low.
// A query holds busy through these steps: per access point one entry read,
// 49 restoring divide steps (log squaring runs beside them), one log scaling
// and one accumulate step; then the min word ripples through the cell row,
// one cell a cycle.
// rst is synchronous; tables hold no reset value. done pulses one cycle.
`include "gaussian_fingerprint_matcher_macros.svh"
module gaussian_fingerprint_matcher (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               operation,
  input  logic [2:0]         location,
  input  logic [1:0]         access_point,
  input  logic [15:0]        entry_mean,
  input  logic [15:0]        entry_spread,
  input  logic [15:0]        reading0,
  input  logic [15:0]        reading1,
  input  logic [15:0]        reading2,
  input  logic [15:0]        reading3,
  output logic               done,
  output logic [2:0]         best_location,
  output logic signed [31:0] best_cost,
  output logic               zero_spread_seen
);
  import gfm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ITER, ST_LN, ST_ACC, ST_SCAN, ST_DONE
  } state_t;

  state_t st;
  logic [AP_IDX_W-1:0]  ap;
  logic [DIV_CNT_W-1:0] iter;
  logic [LOC_IDX_W-1:0] scan_cnt;
  logic [15:0] rd [NUM_READINGS];
  logic [15:0] reading_cur;
  logic [2:0]  ap_ext;
  logic        accept;
  logic        query;
  gfm_ctl_t    ctl;
  gfm_link_t   links [NUM_LOCATIONS+1];
  logic [AP_IDX_W-1:0] cell_ap;
  logic        wr_ok;

  assign accept = start && !busy;
  assign query  = accept && operation;
  assign busy   = (st != ST_IDLE);
  assign done   = (st == ST_DONE);
  assign wr_ok  = accept && !operation && (32'(access_point) < NUM_ACCESS_POINTS);
  assign cell_ap = busy ? ap : AP_IDX_W'(access_point);

  assign ap_ext      = 3'(ap);
  assign reading_cur = (ap_ext < 3'(NUM_READINGS)) ? rd[ap_ext[1:0]] : '0;

  always_comb begin
    ctl       = '0;
    ctl.clr   = query;
    ctl.load  = (st == ST_LOAD);
    ctl.dstep = (st == ST_ITER);
    ctl.lstep = (st == ST_ITER) && (32'(iter) < LOG_STEPS);
    ctl.fin   = (st == ST_LN);
    ctl.acc   = (st == ST_ACC);
    ctl.scan  = (st == ST_SCAN);
  end

  always_ff @(posedge clk) begin
    if (query) begin
      rd[0] <= reading0;
      rd[1] <= reading1;
      rd[2] <= reading2;
      rd[3] <= reading3;
    end
    if (rst) begin
      st       <= ST_IDLE;
      ap       <= '0;
      iter     <= '0;
      scan_cnt <= '0;
    end else begin
      case (st)
        ST_IDLE: begin
          if (query) begin
            st <= ST_LOAD;
            ap <= '0;
          end
        end
        ST_LOAD: begin
          st   <= ST_ITER;
          iter <= '0;
        end
        ST_ITER: begin
          if (iter == DIV_CNT_W'(DIV_STEPS - 1)) st <= ST_LN;
          else iter <= iter + 1'b1;
        end
        ST_LN: st <= ST_ACC;
        ST_ACC: begin
          if (ap == AP_IDX_W'(NUM_ACCESS_POINTS - 1)) begin
            st       <= ST_SCAN;
            scan_cnt <= '0;
          end else begin
            ap <= ap + 1'b1;
            st <= ST_LOAD;
          end
        end
        ST_SCAN: begin
          if (scan_cnt == LOC_IDX_W'(NUM_LOCATIONS - 1)) st <= ST_DONE;
          else scan_cnt <= scan_cnt + 1'b1;
        end
        ST_DONE: st <= ST_IDLE;
        default: st <= ST_IDLE;
      endcase
    end
  end

  assign links[0] = '{cost: COST_MAX, loc: '0, flag: 1'b0};

  for (genvar i = 0; i < NUM_LOCATIONS; i++) begin : g_cell
    gfm_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .we       (wr_ok && (32'(location) == i)),
      .ap       (cell_ap),
      .wmean    (entry_mean),
      .wspread  (entry_spread),
      .reading  (reading_cur),
      .is_first (i == 0),
      .my_loc   (LOC_IDX_W'(i)),
      .link_in  (links[i]),
      .link_out (links[i+1])
    );
  end

  assign best_location    = 3'(links[NUM_LOCATIONS].loc);
  assign best_cost        = links[NUM_LOCATIONS].cost;
  assign zero_spread_seen = links[NUM_LOCATIONS].flag;

  `GFM_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `GFM_ASSERT_NEXT(a_query_busy, start && !busy && operation, busy, "query not started")
  `GFM_ASSERT_NEXT(a_load_idle, start && !busy && !operation, !busy, "load made block busy")
  `GFM_ASSERT(a_busy_origin, $rose(busy) |-> $past(start && operation), "busy without query")

endmodule
